// ===== rtl/core/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

  // Table depth default and register reset values
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;
  localparam logic [7:0]  HEADER_RST     = 8'd24;

  // Register indexes on the configuration port
  localparam logic REG_HEAP_LIMIT = 1'b0;
  localparam logic REG_HEADER     = 1'b1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOROOM  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // One table entry as stored in the block memory
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  // Sequencer steps (program addresses)
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_CHECK     = 4'd1,
    S_SCAN      = 4'd2,
    S_HIT       = 4'd3,
    S_GRANT     = 4'd4,
    S_MARK_FREE = 4'd5,
    S_POP       = 4'd6,
    S_MISS      = 4'd7,
    S_ZERO      = 4'd8,
    S_RESP      = 4'd9
  } step_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NOP,
    A_LATCH,
    A_SCAN_START,
    A_SCAN,
    A_RD_PREV,
    A_GRANT,
    A_MARK_FREE,
    A_POP,
    A_MISS,
    A_ZERO,
    A_PUSH
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ACCEPT,
    C_ZERO,
    C_HIT,
    C_END,
    C_ALLOC,
    C_LAST,
    C_OUT_BUSY
  } cond_t;

  // Control word: action, two conditional jumps, default successor
  typedef struct packed {
    act_t  act;
    cond_t c1;
    step_t t1;
    cond_t c2;
    step_t t2;
    step_t nxt;
  } ucw_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic accept;
    logic zero;
    logic hit;
    logic scan_end;
    logic alloc;
    logic last;
  } flags_t;

  // Result of one request
  typedef struct packed {
    logic [31:0] payload_address;
    status_t     status;
  } result_t;

  // Microcode program
  function automatic ucw_t ucode_rom(input step_t s);
    ucw_t w;
    begin
      w = '{A_NOP, C_NONE, S_IDLE, C_NONE, S_IDLE, S_IDLE};
      case (s)
        S_IDLE:      w = '{A_LATCH,      C_ACCEPT,   S_CHECK, C_NONE, S_IDLE,  S_IDLE};
        S_CHECK:     w = '{A_SCAN_START, C_ZERO,     S_ZERO,  C_NONE, S_IDLE,  S_SCAN};
        S_SCAN:      w = '{A_SCAN,       C_HIT,      S_HIT,   C_END,  S_MISS,  S_SCAN};
        S_HIT:       w = '{A_RD_PREV,    C_ALLOC,    S_GRANT, C_LAST, S_POP,
                           S_MARK_FREE};
        S_GRANT:     w = '{A_GRANT,      C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_RESP};
        S_MARK_FREE: w = '{A_MARK_FREE,  C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_RESP};
        S_POP:       w = '{A_POP,        C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_RESP};
        S_MISS:      w = '{A_MISS,       C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_RESP};
        S_ZERO:      w = '{A_ZERO,       C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_RESP};
        S_RESP:      w = '{A_PUSH,       C_OUT_BUSY, S_RESP,  C_NONE, S_IDLE,  S_IDLE};
        default:     w = '{A_NOP,        C_NONE,     S_IDLE,  C_NONE, S_IDLE,  S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ffa_ifs.sv =====
`default_nettype none
// Request channel: allocate or release
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] request_size;
  logic [31:0] release_address;

  modport source (output valid, opcode, request_size, release_address, input ready);
  modport sink   (input valid, opcode, request_size, release_address, output ready);
endinterface

// Result channel
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_address;
  logic [1:0]  status;

  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffa_ucode.sv =====
`default_nettype none
module ffa_ucode
  import ffa_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  input  wire logic   out_busy,
  output act_t        act
);

  step_t pc_r, pc_nxt;
  ucw_t  word;

  function automatic logic cond_met(input cond_t c, input flags_t f, input logic busy);
    logic r;
    begin
      case (c)
        C_NONE:     r = 1'b0;
        C_ACCEPT:   r = f.accept;
        C_ZERO:     r = f.zero;
        C_HIT:      r = f.hit;
        C_END:      r = f.scan_end;
        C_ALLOC:    r = f.alloc;
        C_LAST:     r = f.last;
        C_OUT_BUSY: r = busy;
        default:    r = 1'b0;
      endcase
      return r;
    end
  endfunction

  assign word = ucode_rom(pc_r);

  // Next step: first jump, second jump, else default successor
  always_comb begin
    if (cond_met(word.c1, flags, out_busy)) begin
      pc_nxt = word.t1;
    end else if (cond_met(word.c2, flags, out_busy)) begin
      pc_nxt = word.t2;
    end else begin
      pc_nxt = word.nxt;
    end
  end

  // Control output
  always_comb begin
    act = word.act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffa_dpath.sv =====
`default_nettype none
module ffa_dpath
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire act_t        act,
  input  wire logic        in_valid,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_request_size,
  input  wire logic [31:0] in_release_address,
  input  wire logic [31:0] heap_limit,
  input  wire logic [7:0]  header_bytes,
  output logic             in_ready,
  output flags_t           flags,
  output result_t          res
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = AW + 1;

  // Block table
  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  // Request and scan registers
  logic          op_r;
  logic [31:0]   size_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] idx_r;
  logic          chk_vld_r;
  logic [AW-1:0] chk_idx_r;
  entry_t        ent_r;
  logic [AW-1:0] ent_idx_r;
  logic [CW-1:0] count_r;
  logic [31:0]   break_r;
  result_t       res_r;

  logic          accept;
  logic          hit;
  logic [33:0]   total;
  logic          no_room;
  logic [32:0]   ent_end;
  logic [31:0]   new_start;

  assign in_ready = (act == A_LATCH);
  assign accept   = in_valid && in_ready;

  // Match test on the entry read out this cycle
  always_comb begin
    if (op_r == OP_ALLOC) begin
      hit = chk_vld_r && rd_q.free && (rd_q.size >= size_r);
    end else begin
      hit = chk_vld_r && (rd_q.start == addr_r);
    end
  end

  // Append room check, computed without wrap
  assign total     = {2'b00, break_r} + {26'd0, header_bytes} + {2'b00, size_r};
  assign no_room   = (count_r >= CW'(MAX_BLOCKS)) || (total > {2'b00, heap_limit});
  assign new_start = break_r + {24'd0, header_bytes};
  assign ent_end   = {1'b0, ent_r.start} + {1'b0, ent_r.size};

  always_comb begin
    flags.accept   = accept;
    flags.zero     = (op_r == OP_ALLOC) && (size_r == 32'd0);
    flags.hit      = hit;
    flags.scan_end = !chk_vld_r && (idx_r >= count_r);
    flags.alloc    = (op_r == OP_ALLOC);
    flags.last     = (({1'b0, ent_idx_r} + CW'(1)) == count_r) && (ent_end == {1'b0, break_r});
  end

  assign res = res_r;

  // Memory port control
  always_comb begin
    rd_addr = (act == A_RD_PREV) ? (ent_idx_r - 1'b1) : idx_r[AW-1:0];
    we      = 1'b0;
    wa      = ent_idx_r;
    wd      = ent_r;
    case (act)
      A_GRANT: begin
        we      = 1'b1;
        wd.free = 1'b0;
      end
      A_MARK_FREE: begin
        we      = 1'b1;
        wd.free = 1'b1;
      end
      A_MISS: begin
        we = (op_r == OP_ALLOC) && !no_room;
        wa = count_r[AW-1:0];
        wd = '{start: new_start, size: size_r, free: 1'b0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Request latch, scan pointer and captured entry
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      size_r <= in_request_size;
      addr_r <= in_release_address;
    end
    if (act == A_SCAN_START) begin
      idx_r <= '0;
    end else if (act == A_SCAN && idx_r < count_r) begin
      idx_r <= idx_r + 1'b1;
    end
    if (act == A_SCAN) begin
      chk_idx_r <= idx_r[AW-1:0];
      if (chk_vld_r) begin
        ent_r     <= rd_q;
        ent_idx_r <= chk_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (act == A_SCAN) begin
      chk_vld_r <= (idx_r < count_r);
    end else begin
      chk_vld_r <= 1'b0;
    end
  end

  // Table size and break
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      break_r <= '0;
    end else if (act == A_POP) begin
      count_r <= {1'b0, ent_idx_r};
      break_r <= (ent_idx_r == '0) ? 32'd0 : (rd_q.start + rd_q.size);
    end else if (act == A_MISS && op_r == OP_ALLOC && !no_room) begin
      count_r <= count_r + 1'b1;
      break_r <= total[31:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    case (act)
      A_GRANT:     res_r <= '{payload_address: ent_r.start, status: ST_OK};
      A_MARK_FREE: res_r <= '{payload_address: 32'd0, status: ST_OK};
      A_POP:       res_r <= '{payload_address: 32'd0, status: ST_OK};
      A_ZERO:      res_r <= '{payload_address: 32'd0, status: ST_ZERO};
      A_MISS: begin
        if (op_r == OP_RELEASE) begin
          res_r <= '{payload_address: 32'd0,
                     status: (addr_r == 32'd0) ? ST_OK : ST_UNKNOWN};
        end else if (no_room) begin
          res_r <= '{payload_address: 32'd0, status: ST_NOROOM};
        end else begin
          res_r <= '{payload_address: new_start, status: ST_OK};
        end
      end
      default: res_r <= res_r;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// The scan reads one table entry per cycle from the block memory; a zero-size
// allocate skips the scan. A new request is accepted only in the idle step,
// after the previous result has been handed to the output register.
// Reset (rst_n low, synchronous): table empty, break 0, heap_limit 1048576,
// header_bytes 24, no result pending. Table contents need no clearing.
`default_nettype none
module first_fit_heap_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ffa_req_if.sink          in_req,
  ffa_rsp_if.source        out_rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] heap_limit_r;
  logic [7:0]  header_bytes_r;
  act_t        act;
  flags_t      flags;
  result_t     res;
  logic        out_valid_r;
  result_t     out_r;
  logic        out_busy;
  logic        cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, header_bytes_r} : heap_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r   <= HEAP_LIMIT_RST;
      header_bytes_r <= HEADER_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEAP_LIMIT) begin
        heap_limit_r <= pwdata;
      end else begin
        header_bytes_r <= pwdata[7:0];
      end
    end
  end

  // Sequencer
  assign out_busy = out_valid_r && !out_rsp.ready;

  ffa_ucode u_ucode (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .out_busy (out_busy),
    .act      (act)
  );

  // Datapath and block table
  ffa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .act                (act),
    .in_valid           (in_req.valid),
    .in_opcode          (in_req.opcode),
    .in_request_size    (in_req.request_size),
    .in_release_address (in_req.release_address),
    .heap_limit         (heap_limit_r),
    .header_bytes       (header_bytes_r),
    .in_ready           (in_req.ready),
    .flags              (flags),
    .res                (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (act == A_PUSH && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act == A_PUSH && !out_busy) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.payload_address = out_r.payload_address;
  assign out_rsp.status          = out_r.status;

endmodule
`default_nettype wire
